// ===== hdl/frc_pkg.sv =====
// Package for the clockwise frame rotator: sizes, register indexes, action codes,
// the request struct between address generator and top level, and dimension clamping.
// Depends on nothing; every other file of the block but frc_ram imports it.
`default_nettype none

package frc_pkg;

  localparam int MAX_DIM   = 256;
  localparam int COORD_W   = $clog2(MAX_DIM);
  localparam int DIM_W     = $clog2(MAX_DIM + 1);
  localparam int ADDR_W    = 2 * COORD_W;
  localparam int TOTAL_W   = $clog2(MAX_DIM * MAX_DIM + 1);
  localparam int CHAN_W    = 8;
  localparam int PIX_W     = 4 * CHAN_W;
  localparam int CFG_W     = 9;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_ALPHA_PRESENT = 2'd2
  } reg_index_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_EMIT = 1'b1
  } action_t;

  // One frame store access, issued in the cycle a beat is accepted.
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] addr;
    logic              last;
    logic              alpha;
  } mem_req_t;

  // A zero dimension acts as one, anything above MAX_DIM acts as MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (int'(v) > MAX_DIM) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/frc_pix_if.sv =====
// Pixel stream interfaces of the clockwise frame rotator: input beats and result beats,
// each with valid, ready and payload. Depends on frc_pkg for the channel width.
`default_nettype none

interface frc_pix_in_if;
  import frc_pkg::*;
  logic              valid;
  logic              ready;
  logic              action;
  logic [CHAN_W-1:0] red_in;
  logic [CHAN_W-1:0] green_in;
  logic [CHAN_W-1:0] blue_in;
  logic [CHAN_W-1:0] alpha_in;

  modport source (output valid, action, red_in, green_in, blue_in, alpha_in, input ready);
  modport sink   (input valid, action, red_in, green_in, blue_in, alpha_in, output ready);
endinterface

interface frc_pix_out_if;
  import frc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red_out;
  logic [CHAN_W-1:0] green_out;
  logic [CHAN_W-1:0] blue_out;
  logic [CHAN_W-1:0] alpha_out;
  logic              last_of_frame;

  modport source (output valid, red_out, green_out, blue_out, alpha_out, last_of_frame,
                  input ready);
  modport sink   (input valid, red_out, green_out, blue_out, alpha_out, last_of_frame,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/frc_ram.sv =====
// Generic single-port-write, single-port-read synchronous RAM with registered read data.
// Holds the frame store; no dependencies.
`default_nettype none

module frc_ram #(
  parameter int ADDR_W = 16,
  parameter int DATA_W = 32
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/frc_agen.sv =====
// Address generator of the clockwise frame rotator: load index and emit row/column
// counters, and the frame store address of each accepted beat. Depends on frc_pkg.
`default_nettype none

module frc_agen
  import frc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  action_t          action,
  input  logic [DIM_W-1:0] width,
  input  logic [DIM_W-1:0] height,
  input  logic             alpha_present,
  output mem_req_t         req
);

  logic [ADDR_W-1:0]  load_index;
  logic [ADDR_W-1:0]  load_index_next;
  logic [COORD_W-1:0] emit_row;
  logic [COORD_W-1:0] emit_row_next;
  logic [COORD_W-1:0] emit_col;
  logic [COORD_W-1:0] emit_col_next;

  logic [2*DIM_W-1:0] total_prod;
  logic [TOTAL_W-1:0] total;
  logic [ADDR_W-1:0]  load_addr;
  logic [TOTAL_W-1:0] load_inc;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;
  logic [DIM_W-1:0]   src_row;
  logic [2*DIM_W-1:0] emit_prod;
  logic [ADDR_W-1:0]  emit_addr;
  logic [DIM_W-1:0]   row_inc;
  logic [DIM_W-1:0]   col_inc;
  logic               is_last;

  always_comb begin
    total_prod = width * height;
    total      = TOTAL_W'(total_prod);

    // Load side: an index left beyond a shrunken frame restarts at zero.
    load_addr = (TOTAL_W'(load_index) >= total) ? '0 : load_index;
    load_inc  = TOTAL_W'(load_addr) + TOTAL_W'(1);
    load_index_next = (load_inc >= total) ? '0 : load_inc[ADDR_W-1:0];

    // Emit side: target (row, col) reads source row height-1-col, column row.
    row       = (DIM_W'(emit_row) >= width)  ? '0 : emit_row;
    col       = (DIM_W'(emit_col) >= height) ? '0 : emit_col;
    src_row   = height - DIM_W'(1) - DIM_W'(col);
    emit_prod = src_row * width;
    emit_addr = ADDR_W'(emit_prod + (2*DIM_W)'(row));
    is_last   = (DIM_W'(row) == width - DIM_W'(1)) && (DIM_W'(col) == height - DIM_W'(1));

    row_inc = DIM_W'(row) + DIM_W'(1);
    col_inc = DIM_W'(col) + DIM_W'(1);
    if (col_inc >= height) begin
      emit_col_next = '0;
      emit_row_next = (row_inc >= width) ? '0 : row_inc[COORD_W-1:0];
    end else begin
      emit_col_next = col_inc[COORD_W-1:0];
      emit_row_next = row;
    end

    req.wr_en = accept && (action == ACT_LOAD);
    req.rd_en = accept && (action == ACT_EMIT);
    req.addr  = (action == ACT_LOAD) ? load_addr : emit_addr;
    req.last  = is_last;
    req.alpha = alpha_present;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_index <= '0;
      emit_row   <= '0;
      emit_col   <= '0;
    end else if (accept) begin
      case (action)
        ACT_LOAD: begin
          load_index <= load_index_next;
        end
        ACT_EMIT: begin
          emit_row <= emit_row_next;
          emit_col <= emit_col_next;
        end
        default: begin
          load_index <= load_index;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hdl/frc_obuf.sv =====
// Result buffer of the clockwise frame rotator: output register plus one skid entry that
// catch frame store read data while the downstream side stalls. Depends on frc_pkg and
// frc_pix_out_if.
`default_nettype none

module frc_obuf
  import frc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_valid,
  input  logic [PIX_W-1:0] rd_word,
  input  logic             rd_last,
  input  logic             rd_alpha,
  output logic             room,
  frc_pix_out_if.source    pix_out
);

  logic             out_valid;
  logic [PIX_W-1:0] out_word;
  logic             out_last;
  logic             skid_valid;
  logic [PIX_W-1:0] skid_word;
  logic             skid_last;

  logic             pop;
  logic             out_free;
  logic [1:0]       occ;
  logic [PIX_W-1:0] rd_masked;

  always_comb begin
    pop       = out_valid && pix_out.ready;
    out_free  = !out_valid || pop;
    occ       = 2'(out_valid) + 2'(skid_valid) + 2'(rd_valid);
    // At most two results are ever in flight here, counting a read under way.
    room      = (occ < 2'd2) || pop;
    rd_masked = rd_alpha ? rd_word : {{CHAN_W{1'b0}}, rd_word[PIX_W-CHAN_W-1:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= rd_valid;
      end else begin
        out_valid  <= rd_valid;
      end
    end else if (rd_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_word  <= skid_word;
        out_last  <= skid_last;
        skid_word <= rd_masked;
        skid_last <= rd_last;
      end else begin
        out_word <= rd_masked;
        out_last <= rd_last;
      end
    end else if (rd_valid) begin
      skid_word <= rd_masked;
      skid_last <= rd_last;
    end
  end

  assign pix_out.valid         = out_valid;
  assign pix_out.red_out       = out_word[CHAN_W-1:0];
  assign pix_out.green_out     = out_word[2*CHAN_W-1:CHAN_W];
  assign pix_out.blue_out      = out_word[3*CHAN_W-1:2*CHAN_W];
  assign pix_out.alpha_out     = out_word[4*CHAN_W-1:3*CHAN_W];
  assign pix_out.last_of_frame = out_last;

endmodule

`default_nettype wire

// ===== hdl/frame_rotate_clockwise.sv =====
// Top level of the clockwise frame rotator: configuration registers, frame store,
// address generator and result buffer. Depends on frc_pkg, frc_pix_if, frc_ram,
// frc_agen and frc_obuf.
`default_nettype none

// The block rotates a frame by 90 degrees clockwise through a frame store of
// MAX_DIM*MAX_DIM 32-bit words (65536 words at the default size). A load beat
// (action 0) writes one source pixel in source raster order and returns nothing;
// an emit beat (action 1) returns one pixel of the rotated frame, which is
// frame_height wide and frame_width tall, in target raster order, with
// last_of_frame set on its final pixel. Both counters wrap, so frames follow
// each other without any restart. While input ready is high, a load or an
// emit can be taken on every clock: loads write the store in the cycle they
// are accepted, emits read it then and their result passes through the
// store's registered read port and then the output register (via the skid
// entry when the output side stalls). Input ready only drops when the output
// side stalls with two results already held (one in the output register, one
// in the skid entry or still in the read port). A load followed at once by an
// emit of the same pixel reads the new value, since the write lands at the
// edge before the read. The store is not cleared after reset and needs no
// clearing pass: emit only pixels of a frame that was fully loaded. Dimensions
// of zero act as one and values above MAX_DIM act as MAX_DIM; the user must
// write configuration only while no beat is in flight; the block won't enforce it.

module frame_rotate_clockwise
  import frc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  frc_pix_in_if.sink           pix_in,
  frc_pix_out_if.source        pix_out,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             alpha_present;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= DIM_RESET;
      frame_height  <= DIM_RESET;
      alpha_present <= 1'b0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        REG_ALPHA_PRESENT: alpha_present <= cfg_data[0];
        default: begin
          frame_width <= frame_width;
        end
      endcase
    end
  end

  logic [DIM_W-1:0] width;
  logic [DIM_W-1:0] height;

  assign width  = clamp_dim(frame_width);
  assign height = clamp_dim(frame_height);

  // Input handshake.
  logic in_accept;
  logic room;

  assign pix_in.ready = room;
  assign in_accept    = pix_in.valid && room;

  // Address generation for the accepted beat.
  mem_req_t req;

  frc_agen u_agen (
    .clk           (clk),
    .rst           (rst),
    .accept        (in_accept),
    .action        (action_t'(pix_in.action)),
    .width         (width),
    .height        (height),
    .alpha_present (alpha_present),
    .req           (req)
  );

  // Alpha is stored as zero in three-channel mode.
  logic [PIX_W-1:0] wr_word;

  assign wr_word = {alpha_present ? pix_in.alpha_in : {CHAN_W{1'b0}},
                    pix_in.blue_in, pix_in.green_in, pix_in.red_in};

  logic [PIX_W-1:0] rd_word;

  frc_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (PIX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (req.wr_en),
    .wr_addr (req.addr),
    .wr_data (wr_word),
    .rd_en   (req.rd_en),
    .rd_addr (req.addr),
    .rd_data (rd_word)
  );

  // Side information that travels alongside the read in the store.
  logic rd_valid;
  logic rd_last;
  logic rd_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= req.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_last  <= req.last;
      rd_alpha <= req.alpha;
    end
  end

  frc_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .rd_valid (rd_valid),
    .rd_word  (rd_word),
    .rd_last  (rd_last),
    .rd_alpha (rd_alpha),
    .room     (room),
    .pix_out  (pix_out)
  );

endmodule

`default_nettype wire

// ===== hdl/frc_checker.sv =====
// Port-level checker of the clockwise frame rotator and the bind that attaches it.
// Depends on frc_pkg and the frame_rotate_clockwise top level.
`default_nettype none

module frc_checker
  import frc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              in_action,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAN_W-1:0] out_red,
  input logic              out_last
);

  logic       emit_beat;
  logic       out_beat;
  logic [2:0] pending;

  assign emit_beat = in_valid && in_ready && (action_t'(in_action) == ACT_EMIT);
  assign out_beat  = out_valid && out_ready;

  // Emits accepted whose result beat has not yet been taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + 3'(emit_beat) - 3'(out_beat);
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 3'd0)
    else $error("result beat without an emit beat");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 3'd2)
    else $error("more than two results in flight");

  a_ready_when_idle: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled while output side is empty");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind frame_rotate_clockwise frc_checker u_frc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .in_action (pix_in.action),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .out_red   (pix_out.red_out),
  .out_last  (pix_out.last_of_frame)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench of the clockwise frame rotator: frames are loaded and read back
// rotated, and every result beat is checked in order against a predictor with its own store.
// Depends on frc_pkg, the pixel stream interfaces and the frame_rotate_clockwise top level.
`timescale 1ns / 100ps

module testbench;
  import frc_pkg::*;

  localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
  // Loads write the store in the cycle they are taken and emits return through the
  // read port and output register, so this wait covers anything still in the block.
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LINES  = 100;

  // One input beat: the action and the pixel that a load carries.
  typedef struct packed {
    action_t    act;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_beat_t;

  // One pixel of the rotated frame as it should leave the block.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
  } rot_pix_t;

  // Scan position: the next store slot to load, and the target row and column
  // of the next emitted pixel.
  typedef struct packed {
    int unsigned load_at;
    int unsigned row;
    int unsigned col;
  } scan_pos_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_W-1:0]     cfg_data  = '0;

  logic      in_valid  = 1'b0;
  pix_beat_t in_beat   = '0;
  logic      out_ready = 1'b0;

  frc_pix_in_if  pix_in_bus ();
  frc_pix_out_if pix_out_bus ();

  assign pix_in_bus.valid    = in_valid;
  assign pix_in_bus.action   = in_beat.act;
  assign pix_in_bus.red_in   = in_beat.red;
  assign pix_in_bus.green_in = in_beat.green;
  assign pix_in_bus.blue_in  = in_beat.blue;
  assign pix_in_bus.alpha_in = in_beat.alpha;
  assign pix_out_bus.ready   = out_ready;

  frame_rotate_clockwise u_dut (
    .clk       (clk),
    .rst       (rst),
    .pix_in    (pix_in_bus),
    .pix_out   (pix_out_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial forever #2 clk = ~clk;

  // Bookkeeping shared by the stimulus, the driver and the result monitor.
  pix_beat_t   pending_beats[$];
  rot_pix_t    rotated_due[$];
  int unsigned beats_queued   = 0;
  int unsigned beats_taken    = 0;
  int unsigned results_seen   = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_no       = 0;

  // The predictor keeps its own copy of the registers, the counters and the store.
  logic [CFG_W-1:0] pred_w_raw = DIM_RESET;
  logic [CFG_W-1:0] pred_h_raw = DIM_RESET;
  logic             pred_alpha = 1'b0;
  scan_pos_t        pred_pos   = '0;
  logic [PIX_W-1:0] rot_store [STORE_DEPTH];

  // The stimulus side mirrors the counters and remembers which slots were ever
  // loaded, so that it never asks for a pixel that the store does not hold.
  int unsigned gen_w   = MAX_DIM;
  int unsigned gen_h   = MAX_DIM;
  scan_pos_t   gen_pos = '0;
  bit          slot_loaded [STORE_DEPTH];

  always @(posedge clk) cycle_no <= cycle_no + 1;

  // A register value of zero acts as one; anything above the largest size acts as it.
  function automatic int unsigned eff_dim(logic [CFG_W-1:0] raw);
    if (raw == '0) return 1;
    if (raw > MAX_DIM) return MAX_DIM;
    return raw;
  endfunction

  // A load counter past the end of the current frame starts over at slot zero.
  function automatic int unsigned load_slot(scan_pos_t p, int unsigned w, int unsigned h);
    return (p.load_at >= w * h) ? 0 : p.load_at;
  endfunction

  // Likewise a target row or column outside the rotated frame starts over at zero.
  function automatic scan_pos_t fold_emit(scan_pos_t p, int unsigned w, int unsigned h);
    scan_pos_t q;
    q = p;
    if (q.row >= w) q.row = 0;
    if (q.col >= h) q.col = 0;
    return q;
  endfunction

  // Target row r, column c is source row h-1-c, column r.
  function automatic int unsigned emit_slot(scan_pos_t p, int unsigned w, int unsigned h);
    scan_pos_t q;
    q = fold_emit(p, w, h);
    return (h - 1 - q.col) * w + q.row;
  endfunction

  function automatic scan_pos_t advance_pos(scan_pos_t p, action_t act, int unsigned w,
                                            int unsigned h);
    scan_pos_t   q;
    int unsigned slot;
    if (act == ACT_LOAD) begin
      q = p;
      slot = load_slot(p, w, h);
      q.load_at = (slot + 1 >= w * h) ? 0 : slot + 1;
    end else begin
      // The rotated frame is scanned column index fastest, wrapping into the next row.
      q = fold_emit(p, w, h);
      q.col = q.col + 1;
      if (q.col >= h) begin
        q.col = 0;
        q.row = (q.row + 1 >= w) ? 0 : q.row + 1;
      end
    end
    return q;
  endfunction

  // Works out what one accepted beat does: a load fills a slot, an emit adds an
  // expected pixel. Alpha is kept only in four-channel mode and only shown in it.
  function automatic void predict_beat(pix_beat_t b);
    int unsigned      w;
    int unsigned      h;
    scan_pos_t        q;
    logic [PIX_W-1:0] word;
    rot_pix_t         due;
    w = eff_dim(pred_w_raw);
    h = eff_dim(pred_h_raw);
    if (b.act == ACT_LOAD) begin
      rot_store[load_slot(pred_pos, w, h)] =
        {pred_alpha ? b.alpha : 8'h00, b.blue, b.green, b.red};
    end else begin
      q = fold_emit(pred_pos, w, h);
      word = rot_store[emit_slot(pred_pos, w, h)];
      due.red   = word[7:0];
      due.green = word[15:8];
      due.blue  = word[23:16];
      due.alpha = pred_alpha ? word[31:24] : 8'h00;
      due.last  = (q.row == w - 1) && (q.col == h - 1);
      rotated_due.push_back(due);
    end
    pred_pos = advance_pos(pred_pos, b.act, w, h);
  endfunction

  // Each side holds off at random about 14 percent of the time, except in a long calm
  // window that recurs with the cycle count and lets the block run flat out.
  function automatic bit bubble_now();
    if ((cycle_no % 3000) >= 400 && (cycle_no % 3000) < 1200) return 1'b0;
    return $urandom_range(99) < 14;
  endfunction

  task automatic report_mismatch(string what, int unsigned want, int unsigned got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LINES)
      $display("%0t: result beat %0d, %s: expected %0h, got %0h",
               $time, results_seen, what, want, got);
  endtask

  // Input driver. The beat on the bus is predicted at the edge where it is taken,
  // and a new one is offered once the bus is free. Register writes are mirrored
  // here too, so the predictor sees them at the same edge as the block does.
  always @(posedge clk) begin : drive_pixels
    bit slot_free;
    if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:   pred_w_raw = cfg_data;
        REG_FRAME_HEIGHT:  pred_h_raw = cfg_data;
        REG_ALPHA_PRESENT: pred_alpha = cfg_data[0];
        default: ;
      endcase
    end
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && pix_in_bus.ready) begin
        predict_beat(in_beat);
        beats_taken++;
      end
      slot_free = !in_valid || pix_in_bus.ready;
      if (slot_free) begin
        if (pending_beats.size() != 0 && !bubble_now()) begin
          in_beat  <= pending_beats.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every taken result beat is compared field by field with the
  // oldest expected pixel.
  always @(posedge clk) begin : watch_pixels
    rot_pix_t got;
    rot_pix_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (pix_out_bus.valid && out_ready) begin
        got = {pix_out_bus.red_out, pix_out_bus.green_out, pix_out_bus.blue_out,
               pix_out_bus.alpha_out, pix_out_bus.last_of_frame};
        if (rotated_due.size() == 0) begin
          report_mismatch("beat with no pixel pending", 0, 1);
        end else begin
          want = rotated_due.pop_front();
          if (got.red !== want.red)     report_mismatch("red_out", want.red, got.red);
          if (got.green !== want.green) report_mismatch("green_out", want.green, got.green);
          if (got.blue !== want.blue)   report_mismatch("blue_out", want.blue, got.blue);
          if (got.alpha !== want.alpha) report_mismatch("alpha_out", want.alpha, got.alpha);
          if (got.last !== want.last)
            report_mismatch("last_of_frame", want.last, got.last);
        end
        results_seen++;
      end
      out_ready <= !bubble_now();
    end
  end

  // Adds a beat to the pending queue and keeps the stimulus mirror in step.
  function automatic void queue_beat(action_t act, logic [7:0] red, logic [7:0] green,
                                     logic [7:0] blue, logic [7:0] alpha);
    if (act == ACT_LOAD) slot_loaded[load_slot(gen_pos, gen_w, gen_h)] = 1'b1;
    gen_pos = advance_pos(gen_pos, act, gen_w, gen_h);
    pending_beats.push_back('{act, red, green, blue, alpha});
    beats_queued++;
  endfunction

  // A random beat. An emit is only issued when the pixel it reads was loaded at
  // some point; otherwise a load goes out instead.
  function automatic void queue_random(bit try_emit);
    action_t act;
    act = (try_emit && slot_loaded[emit_slot(gen_pos, gen_w, gen_h)]) ? ACT_EMIT : ACT_LOAD;
    queue_beat(act, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  // Returns once every queued beat was taken, every expected pixel came back and
  // a settling wait let the block finish a trailing load.
  task automatic wait_quiet();
    do @(posedge clk); while (beats_taken != beats_queued || rotated_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Registers are only written while nothing is in flight.
  task automatic set_geometry(logic [CFG_W-1:0] w_raw, logic [CFG_W-1:0] h_raw,
                              bit alpha_on);
    wait_quiet();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= w_raw;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= h_raw;
    @(posedge clk);
    cfg_index <= REG_ALPHA_PRESENT;
    cfg_data  <= CFG_W'(alpha_on);
    @(posedge clk);
    cfg_we <= 1'b0;
    gen_w = eff_dim(w_raw);
    gen_h = eff_dim(h_raw);
  endtask

  // A well-formed phase loads one whole frame and then mixes loads and emits at
  // random; without the full frame first, emits appear only where slots from
  // earlier phases allow, and the counters may start outside the new frame.
  task automatic run_phase(logic [CFG_W-1:0] w_raw, logic [CFG_W-1:0] h_raw, bit alpha_on,
                           int unsigned n_mixed, bit full_first);
    set_geometry(w_raw, h_raw, alpha_on);
    if (full_first) repeat (gen_w * gen_h) queue_random(1'b0);
    repeat (n_mixed) queue_random(1'(($urandom_range(1))));
  endtask

  initial begin : stimulus
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: a 2x3 frame with extreme channel values and alpha kept, one extra
    // load so the load counter sits past the next frame, and a partial read-out.
    set_geometry(9'd2, 9'd3, 1'b1);
    queue_beat(ACT_LOAD, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_beat(ACT_LOAD, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_beat(ACT_LOAD, 8'h55, 8'hAA, 8'h0F, 8'hF0);
    queue_beat(ACT_LOAD, 8'hAA, 8'h55, 8'hF0, 8'h0F);
    queue_beat(ACT_LOAD, 8'h01, 8'h80, 8'h7F, 8'hFE);
    queue_beat(ACT_LOAD, 8'hFE, 8'h7F, 8'h80, 8'h01);
    queue_beat(ACT_LOAD, 8'h12, 8'h34, 8'h56, 8'h78);
    repeat (4) queue_beat(ACT_EMIT, 8'hFF, 8'hFF, 8'hFF, 8'hFF);

    // Zero dimensions act as a single pixel, so both counters are out of range
    // and restart. Each emit right after a load must return the new pixel, with
    // alpha dropped and the frame end flagged every time.
    set_geometry(9'd0, 9'd0, 1'b0);
    queue_beat(ACT_LOAD, 8'hC3, 8'h3C, 8'h99, 8'hFF);
    queue_beat(ACT_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_beat(ACT_LOAD, 8'h3C, 8'hC3, 8'h66, 8'hFF);
    queue_beat(ACT_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);

    // Back to 2x3 without alpha: pixels stored with alpha must now read it as zero.
    set_geometry(9'd2, 9'd3, 1'b0);
    repeat (2) queue_beat(ACT_EMIT, 8'h00, 8'h00, 8'h00, 8'h00);

    // Random frames of many shapes, including oversized dimension values.
    run_phase(9'd5, 9'd7, 1'b1, 80, 1'b1);
    run_phase(9'd1, 9'd1, 1'b0, 30, 1'b1);
    run_phase(9'd8, 9'd1, 1'b1, 40, 1'b1);
    run_phase(9'd1, 9'd9, 1'b0, 40, 1'b1);
    run_phase(9'd300, 9'd1, 1'b1, 60, 1'b1);
    run_phase(9'd0, 9'd300, 1'b0, 60, 1'b1);
    run_phase(9'd4, 9'd4, 1'b1, 50, 1'b0);
    run_phase(9'd10, 9'd8, 1'b1, 100, 1'b1);
    run_phase(9'd3, 9'd5, 1'b0, 60, 1'b1);
    while (beats_queued < 1200)
      run_phase(9'($urandom_range(12)), 9'($urandom_range(12)), 1'($urandom_range(1)),
                $urandom_range(20, 120), $urandom_range(9) != 0);

    wait_quiet();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin : watchdog
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/frc_pkg.sv
hdl/frc_pix_if.sv
hdl/frc_ram.sv
hdl/frc_agen.sv
hdl/frc_obuf.sv
hdl/frame_rotate_clockwise.sv
hdl/frc_checker.sv
tb/testbench.sv
